// File: sv/smam_pkg.sv
// Shared types and constants for the sensor moving-average monitor.
// Holds the result status codes, register indexes, reset values and the divider request.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package smam_pkg;

   // Width of a reading, a threshold, an identifier and the average.
   localparam int DATA_W = 16;

   // Result status codes as they appear on the result word.
   typedef enum logic [2:0] {
      STAT_LOADED  = 3'd0,
      STAT_FULL    = 3'd1,
      STAT_UNKNOWN = 3'd2,
      STAT_FILLING = 3'd3,
      STAT_NORMAL  = 3'd4,
      STAT_HOT     = 3'd5,
      STAT_COLD    = 3'd6,
      STAT_END     = 3'd7
   } status_type;

   // Register index, taken from bit 2 of the byte address.
   localparam logic REG_MAX_TEMP = 1'b0;
   localparam logic REG_MIN_TEMP = 1'b1;

   // Threshold reset values in Q8.8 (20.0 and 10.0 degrees).
   localparam logic signed [DATA_W-1:0] MAX_TEMP_RESET = 16'sd5120;
   localparam logic signed [DATA_W-1:0] MIN_TEMP_RESET = 16'sd2560;

   // Request to the window divider.
   typedef struct packed {
      logic start;
      logic negative;
   } div_req_type;

endpackage

`default_nettype wire

// File: sv/smam_const_div.sv
// Divider of a signed window sum by the constant window length.
// Multiplies the magnitude by a scaled reciprocal and registers the quotient together with done.
// Depends on smam_pkg for the data width and the request struct.
`default_nettype none

module smam_const_div #(
   parameter int DIVISOR = 5,
   parameter int IN_W    = 19
) (
   input  wire                                clock,
   input  wire                                reset,
   input  smam_pkg::div_req_type              div_req,
   input  wire [IN_W-1:0]                     magnitude,
   output logic                               done,
   output logic signed [smam_pkg::DATA_W-1:0] quotient
);

   // With the shift at IN_W + log2(DIVISOR) bits, the rounding error of the reciprocal stays
   // below one quotient step for every magnitude of IN_W bits, so the floor is exact.
   localparam int SHIFT  = IN_W + $clog2(DIVISOR);
   localparam int RCP_W  = IN_W + 1;
   localparam int PROD_W = IN_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIPROCAL =
      RCP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic                        done_ff, done_in;
   logic                        neg_ff, neg_in;
   logic [smam_pkg::DATA_W-1:0] q_ff, q_in;
   logic [PROD_W-1:0]           product;

   assign product = {{RCP_W{1'b0}}, magnitude} * {{IN_W{1'b0}}, RECIPROCAL};

   always_comb begin
      done_in = div_req.start;
      neg_in  = neg_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         neg_in = div_req.negative;
         q_in   = product[SHIFT +: smam_pkg::DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   // The quotient magnitude always fits the data width; the sign is applied last.
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: sv/sensor_moving_average_monitor.sv
// Sensor moving-average monitor: a table of sensors, each paired with a room and a ring of
// the last WINDOW_LENGTH readings. A load word appends a sensor-to-room entry and restarts its
// window; a table that is already full answers "table full" and changes nothing. A measurement
// word with sensor ID zero answers "end of stream". Any other measurement finds the first,
// oldest entry with that ID ("unknown id" if none), stores the Q8.8 reading in its ring and
// answers "filling" until the ring holds WINDOW_LENGTH readings; from then on it answers the
// window average, truncated toward zero, classed as too hot (sum above WINDOW_LENGTH times
// max_temp), too cold (sum below WINDOW_LENGTH times min_temp) or normal. Every input word
// gives exactly one result word. The sensor table and the sample rings live in two
// single-port-write memories with a registered read, and the block works on one word at a
// time. A load takes the word, writes the new entry and hands its result to the output
// register. A measurement takes the word, searches the table entry by entry until the
// matching entry or the end of the loaded entries, updates the entry and its ring, and,
// once the window is full, reads the samples, compares the sum and divides it in the
// reciprocal divider; it then hands the result to the output register. In the worst case
// the search over the table memory is the longest step. A new word is taken while the
// previous result still waits in the output register; the block stalls in its last state
// only while that register is still full. The user must write the thresholds over the
// APB-style port at byte address 0 (max_temp) and 4 (min_temp) only while the block is idle;
// the block itself does not enforce this.
// Depends on smam_pkg and smam_const_div.
`default_nettype none

module sensor_moving_average_monitor #(
   parameter int TABLE_ENTRIES = 64,
   parameter int WINDOW_LENGTH = 5
) (
   input  wire                clock,
   input  wire                reset,
   // Input words.
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_action,
   input  wire [15:0]         req_sensor_ident,
   input  wire [15:0]         req_room_ident,
   input  wire signed [15:0]  req_reading,
   // Result words.
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_room_out,
   output logic [15:0]        rsp_sensor_out,
   output logic signed [15:0] rsp_average,
   // Configuration port.
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire [2:0]          csr_paddr,
   input  wire [31:0]         csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int DATA_W     = smam_pkg::DATA_W;
   localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WP_W       = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int FC_W       = $clog2(WINDOW_LENGTH + 1);
   localparam int SAMP_DEPTH = TABLE_ENTRIES * WINDOW_LENGTH;
   localparam int SA_W       = (SAMP_DEPTH > 1) ? $clog2(SAMP_DEPTH) : 1;
   localparam int SUM_W      = DATA_W + WP_W;
   localparam int ENT_W      = 2 * DATA_W + WP_W + FC_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOAD   = 8'b0000_0010,
      S_SEARCH = 8'b0000_0100,
      S_UPDATE = 8'b0000_1000,
      S_SUM    = 8'b0001_0000,
      S_CLASS  = 8'b0010_0000,
      S_DIVIDE = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   // Control state.
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           loaded_ff, loaded_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic                       issued_ff, issued_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   max_temp_ff, max_temp_in;
   logic signed [DATA_W-1:0]   min_temp_ff, min_temp_in;

   // Working payload.
   logic [IDX_W-1:0]           issued_idx_ff, issued_idx_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [DATA_W-1:0]          sensor_ff, sensor_in;
   logic [DATA_W-1:0]          room_req_ff, room_req_in;
   logic signed [DATA_W-1:0]   reading_ff, reading_in;
   logic [WP_W-1:0]            wpos_ff, wpos_in;
   logic [FC_W-1:0]            fill_ff, fill_in;
   logic [SA_W-1:0]            base_ff, base_in;
   logic [FC_W-1:0]            slot_ff, slot_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   smam_pkg::status_type       res_status_ff, res_status_in;
   logic [DATA_W-1:0]          res_room_ff, res_room_in;
   logic signed [DATA_W-1:0]   res_avg_ff, res_avg_in;

   // Output register.
   smam_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]          rsp_room_ff, rsp_room_in;
   logic [DATA_W-1:0]          rsp_sensor_ff, rsp_sensor_in;
   logic signed [DATA_W-1:0]   rsp_avg_ff, rsp_avg_in;

   // Sensor table: identifier, room, ring write position and fill count per entry.
   logic [ENT_W-1:0]           entry_ram [TABLE_ENTRIES];
   logic                       ent_we, ent_re;
   logic [IDX_W-1:0]           ent_waddr;
   logic [ENT_W-1:0]           ent_wdata;
   logic [ENT_W-1:0]           ent_rdata_ff;
   logic [DATA_W-1:0]          rd_id, rd_room;
   logic [WP_W-1:0]            rd_wpos;
   logic [FC_W-1:0]            rd_fill;

   // Sample rings, WINDOW_LENGTH consecutive words per entry.
   logic signed [DATA_W-1:0]   sample_ram [SAMP_DEPTH];
   logic                       samp_we, samp_re;
   logic [SA_W-1:0]            samp_waddr, samp_raddr;
   logic signed [DATA_W-1:0]   samp_rdata_ff;

   logic                       search_issue, sum_issue;
   logic [SA_W-1:0]            base_now;
   logic [WP_W-1:0]            new_wpos;
   logic [FC_W-1:0]            new_fill;
   logic signed [SUM_W-1:0]    hot_lim, cold_lim;
   logic                       csr_write;
   smam_pkg::div_req_type      div_req;
   logic [SUM_W-1:0]           div_mag;
   logic                       div_done;
   logic signed [DATA_W-1:0]   div_quotient;

   // ------------------------------------------------------------------------------------------
   // Memories. Reads are registered; the sequencer never reads an entry in the cycle that it
   // writes the same entry, so no forwarding is needed.
   // ------------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_ram[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rdata_ff <= entry_ram[scan_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         sample_ram[samp_waddr] <= reading_ff;
      end
      if (samp_re) begin
         samp_rdata_ff <= sample_ram[samp_raddr];
      end
   end

   assign rd_id   = ent_rdata_ff[ENT_W-1 -: DATA_W];
   assign rd_room = ent_rdata_ff[ENT_W-DATA_W-1 -: DATA_W];
   assign rd_wpos = ent_rdata_ff[WP_W+FC_W-1 -: WP_W];
   assign rd_fill = ent_rdata_ff[FC_W-1:0];

   // The search issues one table read per cycle and compares the word read in the cycle before.
   assign search_issue = (state_ff == S_SEARCH) && (scan_ff < loaded_ff);
   assign ent_re       = search_issue;

   // The sum reads the ring of the matched entry one slot per cycle.
   assign sum_issue  = (state_ff == S_SUM) && (slot_ff < FC_W'(WINDOW_LENGTH));
   assign samp_re    = sum_issue;
   assign samp_raddr = base_ff + SA_W'(slot_ff);

   // Ring bookkeeping for the matched entry: the position wraps and the fill count saturates.
   assign base_now   = SA_W'(hit_idx_ff) * SA_W'(WINDOW_LENGTH);
   assign new_wpos   = (wpos_ff == WP_W'(WINDOW_LENGTH - 1)) ? '0 : wpos_ff + WP_W'(1);
   assign new_fill   = (fill_ff < FC_W'(WINDOW_LENGTH)) ? fill_ff + FC_W'(1) : fill_ff;
   assign samp_we    = (state_ff == S_UPDATE);
   assign samp_waddr = base_now + SA_W'(wpos_ff);

   // A load writes a fresh entry with an empty ring; an update rewrites position and fill.
   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = hit_idx_ff;
      ent_wdata = {sensor_ff, res_room_ff, new_wpos, new_fill};
      if (state_ff == S_LOAD) begin
         ent_we    = 1'b1;
         ent_waddr = loaded_ff[IDX_W-1:0];
         ent_wdata = {sensor_ff, room_req_ff, {WP_W{1'b0}}, {FC_W{1'b0}}};
      end else if (state_ff == S_UPDATE) begin
         ent_we = 1'b1;
      end
   end

   // The class compares the exact sum with the thresholds scaled by the window length.
   assign hot_lim  = SUM_W'(max_temp_ff) * SUM_W'(WINDOW_LENGTH);
   assign cold_lim = SUM_W'(min_temp_ff) * SUM_W'(WINDOW_LENGTH);

   // The divider works on the magnitude; the negated most negative sum reads correctly as
   // an unsigned value.
   assign div_req.start    = (state_ff == S_CLASS);
   assign div_req.negative = acc_ff[SUM_W-1];
   assign div_mag          = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

   smam_const_div #(
      .DIVISOR (WINDOW_LENGTH),
      .IN_W    (SUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .magnitude (div_mag),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   // ------------------------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      scan_in       = scan_ff;
      issued_in     = 1'b0;
      issued_idx_in = issued_idx_ff;
      hit_idx_in    = hit_idx_ff;
      sensor_in     = sensor_ff;
      room_req_in   = room_req_ff;
      reading_in    = reading_ff;
      wpos_in       = wpos_ff;
      fill_in       = fill_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_room_in   = res_room_ff;
      res_avg_in    = res_avg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_room_in   = rsp_room_ff;
      rsp_sensor_in = rsp_sensor_ff;
      rsp_avg_in    = rsp_avg_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sensor_in   = req_sensor_ident;
               room_req_in = req_room_ident;
               reading_in  = req_reading;
               res_avg_in  = '0;
               res_room_in = '0;
               scan_in     = '0;
               if (!req_action) begin
                  if (loaded_ff == CNT_W'(TABLE_ENTRIES)) begin
                     res_status_in = smam_pkg::STAT_FULL;
                     state_in      = S_RESP;
                  end else begin
                     res_status_in = smam_pkg::STAT_LOADED;
                     res_room_in   = req_room_ident;
                     state_in      = S_LOAD;
                  end
               end else if (req_sensor_ident == '0) begin
                  res_status_in = smam_pkg::STAT_END;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_LOAD: begin
            loaded_in = loaded_ff + CNT_W'(1);
            state_in  = S_RESP;
         end

         S_SEARCH: begin
            issued_in     = search_issue;
            issued_idx_in = scan_ff[IDX_W-1:0];
            if (search_issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (issued_ff && (rd_id == sensor_ff)) begin
               hit_idx_in  = issued_idx_ff;
               res_room_in = rd_room;
               wpos_in     = rd_wpos;
               fill_in     = rd_fill;
               state_in    = S_UPDATE;
            end else if (!search_issue) begin
               res_status_in = smam_pkg::STAT_UNKNOWN;
               state_in      = S_RESP;
            end
         end

         S_UPDATE: begin
            base_in = base_now;
            if (new_fill < FC_W'(WINDOW_LENGTH)) begin
               res_status_in = smam_pkg::STAT_FILLING;
               state_in      = S_RESP;
            end else begin
               slot_in  = '0;
               acc_in   = '0;
               state_in = S_SUM;
            end
         end

         S_SUM: begin
            issued_in = sum_issue;
            if (sum_issue) begin
               slot_in = slot_ff + FC_W'(1);
            end
            if (issued_ff) begin
               acc_in = acc_ff + SUM_W'(samp_rdata_ff);
            end
            if (!sum_issue) begin
               state_in = S_CLASS;
            end
         end

         S_CLASS: begin
            if (acc_ff > hot_lim) begin
               res_status_in = smam_pkg::STAT_HOT;
            end else if (acc_ff < cold_lim) begin
               res_status_in = smam_pkg::STAT_COLD;
            end else begin
               res_status_in = smam_pkg::STAT_NORMAL;
            end
            state_in = S_DIVIDE;
         end

         S_DIVIDE: begin
            if (div_done) begin
               res_avg_in = div_quotient;
               state_in   = S_RESP;
            end
         end

         S_RESP: begin
            // Waits here only while the previous result is still held in the output register.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_room_in   = res_room_ff;
               rsp_sensor_in = sensor_ff;
               rsp_avg_in    = res_avg_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------------------------
   // Configuration registers. Bit 2 of the byte address selects the register; byte-lane bits
   // are ignored on writes.
   // ------------------------------------------------------------------------------------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      max_temp_in = max_temp_ff;
      min_temp_in = min_temp_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            smam_pkg::REG_MAX_TEMP: max_temp_in = csr_pwdata[DATA_W-1:0];
            smam_pkg::REG_MIN_TEMP: min_temp_in = csr_pwdata[DATA_W-1:0];
            default:                max_temp_in = max_temp_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[2])
            smam_pkg::REG_MAX_TEMP: csr_prdata = 32'(max_temp_ff);
            smam_pkg::REG_MIN_TEMP: csr_prdata = 32'(min_temp_ff);
            default:                csr_prdata = '0;
         endcase
      end
   end

   // ------------------------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_temp_ff  <= smam_pkg::MAX_TEMP_RESET;
         min_temp_ff  <= smam_pkg::MIN_TEMP_RESET;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         max_temp_ff  <= max_temp_in;
         min_temp_ff  <= min_temp_in;
      end
      scan_ff       <= scan_in;
      issued_idx_ff <= issued_idx_in;
      hit_idx_ff    <= hit_idx_in;
      sensor_ff     <= sensor_in;
      room_req_ff   <= room_req_in;
      reading_ff    <= reading_in;
      wpos_ff       <= wpos_in;
      fill_ff       <= fill_in;
      base_ff       <= base_in;
      slot_ff       <= slot_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_room_ff   <= res_room_in;
      res_avg_ff    <= res_avg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_room_ff   <= rsp_room_in;
      rsp_sensor_ff <= rsp_sensor_in;
      rsp_avg_ff    <= rsp_avg_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_room_out   = rsp_room_ff;
   assign rsp_sensor_out = rsp_sensor_ff;
   assign rsp_average    = rsp_avg_ff;

endmodule

`default_nettype wire

// File: tb/smam_result_checker.sv
// Result checker for the sensor moving-average monitor: watches the input, result and
// configuration ports, predicts every result word and compares it with what the block sends.
// Depends on smam_pkg for the status codes, register indexes and threshold reset values.
module smam_result_checker #(
   parameter int TABLE_ENTRIES = 64,
   parameter int WINDOW_LENGTH = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_action,
   input  logic [15:0]        req_sensor_ident,
   input  logic [15:0]        req_room_ident,
   input  logic signed [15:0] req_reading,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic [15:0]        rsp_room_out,
   input  logic [15:0]        rsp_sensor_out,
   input  logic signed [15:0] rsp_average,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic [31:0]        csr_prdata,
   input  logic               csr_pready,
   output int                 fail_count = 0,
   output int                 pending_words = 0
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      smam_pkg::status_type status;
      logic [15:0]          room;
      logic [15:0]          sensor;
      logic [15:0]          avg;
   } monitor_result_type;

   monitor_result_type expected_results[$];

   // Shadow copy of the sensor table, the sample rings and the thresholds.
   logic [15:0]        sensor_ids [TABLE_ENTRIES];
   logic [15:0]        room_of    [TABLE_ENTRIES];
   logic signed [15:0] samples    [TABLE_ENTRIES][WINDOW_LENGTH];
   int                 slot_next  [TABLE_ENTRIES];
   int                 sample_count [TABLE_ENTRIES];
   int                 table_used;
   logic signed [15:0] hot_limit;
   logic signed [15:0] cold_limit;

   function automatic monitor_result_type predict_result(input logic action,
                                                         input logic [15:0] sid,
                                                         input logic [15:0] room,
                                                         input logic signed [15:0] rd);
      monitor_result_type res;
      int hit;
      int total;
      int i;
      res.status = smam_pkg::STAT_LOADED;
      res.room   = '0;
      res.sensor = sid;
      res.avg    = '0;
      if (!action) begin
         if (table_used >= TABLE_ENTRIES) begin
            res.status = smam_pkg::STAT_FULL;
         end else begin
            sensor_ids[table_used] = sid;
            room_of[table_used] = room;
            for (i = 0; i < WINDOW_LENGTH; i++) samples[table_used][i] = '0;
            slot_next[table_used] = 0;
            sample_count[table_used] = 0;
            table_used++;
            res.room = room;
         end
         return res;
      end
      if (sid == 16'd0) begin
         res.status = smam_pkg::STAT_END;
         return res;
      end
      // The first, oldest entry with a matching identifier wins.
      hit = -1;
      for (i = 0; i < table_used; i++)
         if (hit < 0 && sensor_ids[i] == sid) hit = i;
      if (hit < 0) begin
         res.status = smam_pkg::STAT_UNKNOWN;
         return res;
      end
      samples[hit][slot_next[hit]] = rd;
      slot_next[hit] = (slot_next[hit] + 1) % WINDOW_LENGTH;
      if (sample_count[hit] < WINDOW_LENGTH) sample_count[hit]++;
      res.room = room_of[hit];
      if (sample_count[hit] < WINDOW_LENGTH) begin
         res.status = smam_pkg::STAT_FILLING;
         return res;
      end
      total = 0;
      for (i = 0; i < WINDOW_LENGTH; i++) total += int'(samples[hit][i]);
      res.avg = 16'(total / WINDOW_LENGTH);
      if (total > WINDOW_LENGTH * int'(hot_limit))
         res.status = smam_pkg::STAT_HOT;
      else if (total < WINDOW_LENGTH * int'(cold_limit))
         res.status = smam_pkg::STAT_COLD;
      else
         res.status = smam_pkg::STAT_NORMAL;
      return res;
   endfunction

   function void compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      monitor_result_type want;
      if (reset) begin
         table_used = 0;
         hot_limit  = smam_pkg::MAX_TEMP_RESET;
         cold_limit = smam_pkg::MIN_TEMP_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == smam_pkg::REG_MAX_TEMP) hot_limit = csr_pwdata[15:0];
               else cold_limit = csr_pwdata[15:0];
            end else begin
               compare_field("register read", (csr_paddr[2] == smam_pkg::REG_MAX_TEMP) ?
                             hot_limit : cold_limit, csr_prdata[15:0]);
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_result(req_action, req_sensor_ident,
                                                      req_room_ident, req_reading));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result word with none expected, expected nothing, got %h %h %h %h",
                        $time, rsp_status, rsp_room_out, rsp_sensor_out, rsp_average);
            end else begin
               want = expected_results.pop_front();
               compare_field("status", {13'd0, want.status}, {13'd0, rsp_status});
               compare_field("room_out", want.room, rsp_room_out);
               compare_field("sensor_out", want.sensor, rsp_sensor_out);
               compare_field("average", want.avg, rsp_average);
            end
         end
      end
      pending_words <= expected_results.size();
   end

endmodule

// File: tb/tb_top.sv
// Top of the sensor moving-average monitor testbench: clock, reset, stimulus and verdict.
// Depends on smam_pkg, the monitor RTL and smam_result_checker, which predicts and compares.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = 64;
   localparam int WINDOW_LENGTH = 5;
   // Cycles without any accepted word before the run is declared hung. The slowest
   // legal stretch is the long receiver hold-off plus a long sender gap and the
   // block's own processing of a word, so this leaves a wide margin.
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASE_WORDS = 138;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_action = 1'b0;
   logic [15:0]        req_sensor_ident = '0;
   logic [15:0]        req_room_ident = '0;
   logic signed [15:0] req_reading = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [15:0]        rsp_room_out;
   logic [15:0]        rsp_sensor_out;
   logic signed [15:0] rsp_average;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int fail_count;
   int pending_words;

   // Stimulus bookkeeping: identifiers that made it into the table, so that most
   // measurements hit a real entry, and the thresholds currently programmed.
   logic [15:0]        known_ids[$];
   int                 table_count = 0;
   logic signed [15:0] hot_limit = smam_pkg::MAX_TEMP_RESET;
   logic signed [15:0] cold_limit = smam_pkg::MIN_TEMP_RESET;

   // Sender pacing: a burst forces back-to-back words, a calm stretch has no gaps.
   int burst_left = 0;
   int calm_left = 0;

   // The stimulus asks once for a long receiver hold-off; the receiver process
   // counts it out on its own and remembers that it has done so.
   logic squeeze_req = 1'b0;
   logic squeeze_done = 1'b0;
   int   stall_left = 0;
   int   ready_run = 0;
   int   idle_cycles = 0;

   always #1 clock = ~clock;

   sensor_moving_average_monitor #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_sensor_ident(req_sensor_ident),
      .req_room_ident(req_room_ident),
      .req_reading(req_reading),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_room_out(rsp_room_out),
      .rsp_sensor_out(rsp_sensor_out),
      .rsp_average(rsp_average),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   smam_result_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_sensor_ident(req_sensor_ident),
      .req_room_ident(req_room_ident),
      .req_reading(req_reading),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_room_out(rsp_room_out),
      .rsp_sensor_out(rsp_sensor_out),
      .rsp_average(rsp_average),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending_words(pending_words)
   );

   // Length of one idle stretch: mostly none or a few cycles, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // Offers one word and returns at the clock edge where it is accepted. Valid stays
   // high afterwards, so a following word with no gap goes out back to back; every
   // call starts at a rising edge, which keeps to one assignment per signal per step.
   task automatic send_word(input logic act, input logic [15:0] sid,
                            input logic [15:0] room, input logic signed [15:0] rd);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 99) < 4) begin
         calm_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = idle_length();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_sensor_ident <= sid;
      req_room_ident   <= room;
      req_reading      <= rd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!act && table_count < TABLE_ENTRIES) begin
         known_ids.push_back(sid);
         table_count++;
      end
   endtask

   // Stops offering words and waits until every expected result has come back.
   // The first edge is always taken, since the checker's count is registered.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic csr_access(input logic wr, input logic index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= wr;
      csr_paddr   <= {index, 2'b00};
      // The upper half carries noise; only the low 16 bits form the threshold.
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Programs both thresholds with the block idle and reads them back.
   task automatic set_thresholds(input logic signed [15:0] hot, input logic signed [15:0] cold);
      drain();
      csr_access(1'b1, smam_pkg::REG_MAX_TEMP, hot);
      csr_access(1'b1, smam_pkg::REG_MIN_TEMP, cold);
      csr_access(1'b0, smam_pkg::REG_MAX_TEMP, '0);
      csr_access(1'b0, smam_pkg::REG_MIN_TEMP, '0);
      hot_limit  = hot;
      cold_limit = cold;
   endtask

   // Random traffic. Most of it is runs of measurements to sensors that are in the
   // table, with readings often clustered near a threshold so the windows land on both
   // sides of it and sometimes exactly on it. The rest is loads (which in time fill
   // the table), end-of-stream words and identifiers that are most likely unknown.
   task automatic run_traffic(input int count);
      int words_done;
      int pick;
      int run_len;
      int spread;
      int j;
      int level;
      logic [15:0] sid;
      logic signed [15:0] center;
      logic signed [15:0] rd;
      words_done = 0;
      while (words_done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12 || known_ids.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               sid = 16'd0;
            else if (pick < 25 && known_ids.size() > 0)
               sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
            else
               sid = 16'($urandom);
            send_word(1'b0, sid, 16'($urandom), 16'($urandom));
            words_done++;
         end else if (pick < 16) begin
            send_word(1'b1, 16'd0, 16'($urandom), 16'($urandom));
            words_done++;
         end else if (pick < 22) begin
            send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
            words_done++;
         end else begin
            sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
            pick = $urandom_range(0, 3);
            if (pick == 0) center = hot_limit;
            else if (pick == 1) center = cold_limit;
            else if (pick == 2) center = 16'($urandom);
            else center = '0;
            spread  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            run_len = $urandom_range(1, 8);
            for (j = 0; j < run_len; j++) begin
               level = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
               if (level > 32767) level = 32767;
               if (level < -32768) level = -32768;
               rd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(level);
               send_word(1'b1, sid, 16'($urandom), rd);
            end
            words_done += run_len;
         end
      end
   endtask

   // Receiver: random stalls, mostly short with the odd long one, stretches where it
   // is always ready, and the one long hold-off that the stimulus asks for.
   always @(posedge clock) begin
      if (squeeze_req && !squeeze_done) begin
         rsp_ready    <= 1'b0;
         squeeze_done = 1'b1;
         repeat (300) @(posedge clock);
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (ready_run > 0) begin
            ready_run--;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:19]:  stall_left = idle_length();
               [20:22]: ready_run = $urandom_range(30, 100);
               default: ;
            endcase
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the thresholds at their reset values.
      // End of stream and an unknown identifier before anything is loaded.
      send_word(1'b1, 16'd0, 16'hFFFF, 16'sh7FFF);
      send_word(1'b1, 16'hFFFF, 16'd0, 16'sh8000);
      // Extreme identifier and room, a zero room, a zero identifier and a duplicate.
      send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'sd0);
      send_word(1'b0, 16'd1, 16'd0, 16'sd0);
      send_word(1'b0, 16'd0, 16'h1234, 16'sd0);
      send_word(1'b0, 16'd1, 16'hBEEF, 16'sd0);
      // A window of the largest reading goes too hot, then one of the smallest too cold;
      // the words in between cross from one side to the other while the ring turns over.
      repeat (5) send_word(1'b1, 16'hFFFF, 16'h5555, 16'sh7FFF);
      repeat (5) send_word(1'b1, 16'hFFFF, 16'hAAAA, 16'sh8000);
      // Sensor 1 must hit the older entry. A window exactly at the upper threshold is
      // still normal, and one reading just below it keeps it there.
      repeat (5) send_word(1'b1, 16'd1, 16'd0, smam_pkg::MAX_TEMP_RESET);
      send_word(1'b1, 16'd1, 16'd0, smam_pkg::MAX_TEMP_RESET - 16'sd1);

      // Check the reset values of the registers, then run through the settings.
      drain();
      csr_access(1'b0, smam_pkg::REG_MAX_TEMP, '0);
      csr_access(1'b0, smam_pkg::REG_MIN_TEMP, '0);

      set_thresholds(16'sh7FFF, 16'sh8000);
      run_traffic(PHASE_WORDS);

      // Inverted extremes. This phase opens with a burst of back-to-back words while
      // the receiver holds off, so the output register and the block back up.
      set_thresholds(16'sh8000, 16'sh7FFF);
      squeeze_req <= 1'b1;
      burst_left = 40;
      run_traffic(PHASE_WORDS);

      set_thresholds(16'sd0, 16'sd0);
      run_traffic(PHASE_WORDS);

      set_thresholds(16'($urandom), 16'($urandom));
      run_traffic(PHASE_WORDS);

      set_thresholds(smam_pkg::MAX_TEMP_RESET, smam_pkg::MIN_TEMP_RESET);
      run_traffic(PHASE_WORDS);

      set_thresholds(-16'sd2560, -16'sd5120);
      run_traffic(PHASE_WORDS);

      // Let everything come back, then give the block time to show any stray word.
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
